// ===== sv/bafp_pkg.sv =====
package bafp_pkg;

    // Field and datapath widths.
    localparam int unsigned P_W   = 17;    // pressure sample, 0.01 hPa
    localparam int unsigned ALT_W = 21;    // altitude, 0.1 m, two's complement
    localparam int unsigned LG_W  = 35;    // log2 of a sample, Q30, unsigned
    localparam int unsigned T_W   = 36;    // signed Q30 exponent
    localparam int unsigned U_W   = 36;    // power result, Q30
    localparam int unsigned AUX_W = 58;    // carried altitude of the simpler layers
    localparam int unsigned Q_W   = 22;    // stratosphere quotient bits

    // Layer codes.
    localparam logic [1:0] LAYER_TROPO = 2'd0;
    localparam logic [1:0] LAYER_ISO   = 2'd1;
    localparam logic [1:0] LAYER_STRAT = 2'd2;

    // Layer boundaries in 0.01 hPa.
    localparam logic [P_W-1:0] STRAT_LIMIT = 17'd2550;
    localparam logic [P_W-1:0] TROPO_LIMIT = 17'd67050;

    // Altitude limits in 0.1 m.
    localparam logic signed [AUX_W-1:0] ALT_MAX = 58'sd1000000;
    localparam logic signed [AUX_W-1:0] ALT_MIN = -58'sd20000;

    // Q30 constants.
    localparam logic [29:0] LN2_Q30  = 30'd744261118;
    localparam logic [63:0] C165_Q30 = (64'd165374 << 30) / 64'd100000;
    localparam logic [63:0] C485_Q30 = (64'd485016 << 30) / 64'd100000;

    // Power exponents scaled by one million.
    localparam logic [17:0] K_STRAT = 18'd87812;
    localparam logic [17:0] K_TROPO = 18'd190259;

    // Reciprocals for division by small constants.
    localparam logic [32:0] RECIP_15625 = 33'((64'd1 << 46) / 64'd15625);
    localparam logic [31:0] RECIP_20    = 32'((64'd1 << 32) / 64'd20);
    localparam logic [32:0] K_RECIP [1:12] = '{
        33'((64'd1 << 32) / 64'd1),  33'((64'd1 << 32) / 64'd2),
        33'((64'd1 << 32) / 64'd3),  33'((64'd1 << 32) / 64'd4),
        33'((64'd1 << 32) / 64'd5),  33'((64'd1 << 32) / 64'd6),
        33'((64'd1 << 32) / 64'd7),  33'((64'd1 << 32) / 64'd8),
        33'((64'd1 << 32) / 64'd9),  33'((64'd1 << 32) / 64'd10),
        33'((64'd1 << 32) / 64'd11), 33'((64'd1 << 32) / 64'd12)
    };

    // Sideband that travels with each sample down the pipeline.
    typedef struct packed {
        logic [1:0]              layer;
        logic                    zero;
        logic signed [AUX_W-1:0] aux;
    } bafp_tag_t;

    // Log2 in Q30 by repeated squaring, evaluated at elaboration only.
    function automatic logic [63:0] log2_const(input logic [31:0] v);
        logic [63:0] x;
        logic [63:0] frac;
        logic [63:0] e;
        int          i;
        e    = '0;
        frac = '0;
        for (i = 0; i < 16; i++)
        begin
            if ((v >> (i + 1)) != 0)
                e = 64'(i + 1);
        end
        x = 64'(v) << (30 - e);
        for (i = 1; i <= 30; i++)
        begin
            x = (x * x) >> 30;
            if (x >= (64'd2 << 30))
            begin
                x    = x >> 1;
                frac = frac | (64'd1 << (30 - i));
            end
        end
        return (e << 30) + frac;
    endfunction

    localparam logic [63:0] LOG2_1000 = log2_const(32'd1000);

endpackage

// ===== sv/bafp_log2.sv =====
module bafp_log2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic [bafp_pkg::P_W-1:0]      v,
    input  bafp_pkg::bafp_tag_t           in_tag,
    output logic                          out_vld,
    output logic [bafp_pkg::LG_W-1:0]     lg,
    output bafp_pkg::bafp_tag_t           out_tag
);
    import bafp_pkg::*;

    localparam int unsigned NSQ = 30;

    logic [30:0]   x_reg    [0:NSQ];
    logic [29:0]   frac_reg [0:NSQ];
    logic [4:0]    e_reg    [0:NSQ];
    bafp_tag_t     tag_reg  [0:NSQ];
    logic [NSQ:0]  vld_reg;

    logic [4:0]    e_next;
    logic [30:0]   x_next;

    // Normalise the sample to [1,2) in Q30; the exponent is its leading bit.
    always_comb
    begin
        e_next = '0;
        for (int i = 1; i < P_W; i++)
        begin
            if (v[i])
                e_next = 5'(i);
        end
        x_next = 31'({v, 30'b0} >> e_next);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg[0]    <= x_next;
            frac_reg[0] <= '0;
            e_reg[0]    <= e_next;
            tag_reg[0]  <= in_tag;
        end
    end

    // One fraction bit per squaring stage.
    for (genvar s = 1; s <= NSQ; s++)
    begin : g_sq
        logic [61:0] sq;
        logic [31:0] sqs;
        assign sq  = 62'(x_reg[s-1]) * 62'(x_reg[s-1]);
        assign sqs = sq[61:30];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[s]    <= sqs[31] ? sqs[31:1] : sqs[30:0];
                frac_reg[s] <= frac_reg[s-1] | (sqs[31] ? (30'd1 << (NSQ - s)) : 30'd0);
                e_reg[s]    <= e_reg[s-1];
                tag_reg[s]  <= tag_reg[s-1];
            end
        end
    end

    // Valid bits move with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NSQ-1:0], in_vld};
    end

    assign out_vld = vld_reg[NSQ];
    assign lg      = {e_reg[NSQ], frac_reg[NSQ]};
    assign out_tag = tag_reg[NSQ];

endmodule

// ===== sv/bafp_exp2.sv =====
module bafp_exp2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_vld,
    input  logic signed [bafp_pkg::T_W-1:0] t,
    input  bafp_pkg::bafp_tag_t           in_tag,
    output logic                          out_vld,
    output logic [bafp_pkg::U_W-1:0]      u,
    output bafp_pkg::bafp_tag_t           out_tag
);
    import bafp_pkg::*;

    localparam int unsigned NTERM = 12;
    localparam int unsigned NST   = 2 * NTERM;

    logic signed [6:0] n_reg    [0:NST];
    logic [29:0]       z_reg    [0:NST];
    logic [30:0]       term_reg [0:NST];
    logic [31:0]       sum_reg  [0:NST];
    bafp_tag_t         tag_reg  [0:NST];
    logic [NST+1:0]    vld_reg;
    logic [U_W-1:0]    u_reg;
    bafp_tag_t         otag_reg;

    logic [59:0]       zp;
    logic signed [6:0] nf;
    logic [U_W-1:0]    u_next;

    // Split into integer and fraction, and scale the fraction by ln 2.
    assign zp = 60'(t[29:0]) * 60'(LN2_Q30);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]    <= 7'(t >>> 30);
            z_reg[0]    <= zp[59:30];
            term_reg[0] <= 31'd1 << 30;
            sum_reg[0]  <= 32'd1 << 30;
            tag_reg[0]  <= in_tag;
        end
    end

    // Taylor series: a product stage and a division stage per term.
    for (genvar k = 1; k <= NTERM; k++)
    begin : g_term
        logic [60:0] tp;
        logic [63:0] rp;
        logic [30:0] q0;
        logic [30:0] rem;
        logic [30:0] qt;

        assign tp = 61'(term_reg[2*k-2]) * 61'(z_reg[2*k-2]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[2*k-1] <= tp[60:30];
                n_reg[2*k-1]    <= n_reg[2*k-2];
                z_reg[2*k-1]    <= z_reg[2*k-2];
                sum_reg[2*k-1]  <= sum_reg[2*k-2];
                tag_reg[2*k-1]  <= tag_reg[2*k-2];
            end
        end

        // Divide by the term index through its reciprocal, one correction step.
        always_comb
        begin
            rp  = 64'(term_reg[2*k-1]) * 64'(K_RECIP[k]);
            q0  = rp[62:32];
            rem = term_reg[2*k-1] - 31'(q0 * 31'(k));
            qt  = (rem >= 31'(k)) ? q0 + 31'd1 : q0;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                term_reg[2*k] <= qt;
                sum_reg[2*k]  <= sum_reg[2*k-1] + 32'(qt);
                n_reg[2*k]    <= n_reg[2*k-1];
                z_reg[2*k]    <= z_reg[2*k-1];
                tag_reg[2*k]  <= tag_reg[2*k-1];
            end
        end
    end

    // Scale by the integer power of two.
    always_comb
    begin
        nf = n_reg[NST];
        if (nf > 7'sd4)
            nf = 7'sd4;
        if (nf < -7'sd40)
            u_next = '0;
        else if (nf >= 7'sd0)
            u_next = U_W'(sum_reg[NST]) << nf[2:0];
        else
            u_next = U_W'(sum_reg[NST]) >> 6'(-nf);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= u_next;
            otag_reg <= tag_reg[NST];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NST:0], in_vld};
    end

    assign out_vld = vld_reg[NST+1];
    assign u       = u_reg;
    assign out_tag = otag_reg;

endmodule

// ===== sv/barometric_altitude_from_pressure.sv =====
// Pressure to altitude converter over a three-layer standard atmosphere.
//
// Input stream s_axis: one pressure sample per request, in 0.01 hPa, in
// tdata[16:0]. Output stream m_axis: one result per sample, in order; the
// altitude in 0.1 m sits in tdata[20:0], the layer used and a saturation
// flag in tuser.
//
// The datapath is a fixed pipeline of 88 register stages: 31 for log2 by
// repeated squaring, 7 for scaling, 26 for the Taylor exp2 chain, one for
// the layer formulas and 22 for the bit-per-stage stratosphere divider, and
// the output register. A new sample is accepted every cycle unless a result
// held off on m_axis has frozen the pipeline.
//
// Reset clears all valid bits, so the pipeline comes up empty and ready.
// When the receiver holds off with a result waiting, the whole pipeline
// freezes and s_axis_tready drops; nothing is lost or repeated, and flow
// resumes on the cycle tready returns.
module barometric_altitude_from_pressure (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // [16:0] pressure_centi_hpa, rest zero
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [20:0] altitude_decimeters, rest zero
    output logic [2:0]  m_axis_tuser    // [1:0] atmosphere_layer, [2] saturated
);
    import bafp_pkg::*;

    localparam int unsigned NDIV = Q_W;

    logic                en;
    logic [P_W-1:0]      p;
    bafp_tag_t           tag_in;

    logic                lg_vld;
    logic [LG_W-1:0]     lg;
    bafp_tag_t           lg_tag;

    // Scaling stages.
    logic [6:0]              vld_t;
    logic signed [T_W-1:0]   lgk1_reg;
    logic signed [54:0]      prod2_reg;
    logic signed [66:0]      lnprod2_reg;
    logic [47:0]             a3_reg;
    logic                    neg3_reg;
    logic signed [59:0]      x3_reg;
    logic [56:0]             pph4_reg;
    logic [56:0]             ppl4_reg;
    logic [47:0]             a4_reg;
    logic                    neg4_reg;
    logic [27:0]             y4_reg;
    logic [59:0]             yprod4_reg;
    logic [80:0]             qprod5_reg;
    logic [47:0]             a5_reg;
    logic                    neg5_reg;
    logic [34:0]             q6_reg;
    logic                    rnz6_reg;
    logic                    neg6_reg;
    logic signed [T_W-1:0]   t7_reg;
    bafp_tag_t               tag_t_reg [1:7];

    logic [17:0]             kmul;
    logic signed [48:0]      m3;
    logic signed [66:0]      lnp3;
    logic signed [37:0]      d3;
    logic [34:0]             q0_6;
    logic [47:0]             r6;
    logic [34:0]             q6_next;
    logic                    rnz6_next;
    logic [27:0]             q20;
    logic [27:0]             r20;
    logic [27:0]             iso_alt;
    bafp_tag_t               tag5_next;

    logic                ex_vld;
    logic [U_W-1:0]      u;
    bafp_tag_t           ex_tag;

    // Layer formula stage and divider.
    logic [U_W-1:0]      u1;
    logic [32:0]         cm;
    logic signed [56:0]  tn2;
    bafp_tag_t           tag_d_next;
    logic [51:0]         rem_reg [0:NDIV];
    logic [Q_W-1:0]      quo_reg [0:NDIV];
    logic [32:0]         den_reg [0:NDIV];
    bafp_tag_t           dtag_reg[0:NDIV];
    logic [NDIV:0]       vld_d;

    // Output register.
    logic                out_vld_reg;
    logic [ALT_W-1:0]    alt_reg;
    logic [1:0]          layer_reg;
    logic                sat_reg;
    logic signed [AUX_W-1:0] alt_sel;
    logic [ALT_W-1:0]    alt_next;
    logic                sat_next;

    // The pipeline advances unless a finished result is being held off.
    assign en            = !out_vld_reg || m_axis_tready;
    assign s_axis_tready = en;

    // Pick the layer from the raw sample.
    assign p = s_axis_tdata[P_W-1:0];
    always_comb
    begin
        tag_in.zero = (p == '0);
        tag_in.aux  = '0;
        if (p < STRAT_LIMIT)
            tag_in.layer = LAYER_STRAT;
        else if (p < TROPO_LIMIT)
            tag_in.layer = LAYER_ISO;
        else
            tag_in.layer = LAYER_TROPO;
    end

    bafp_log2 u_log2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (s_axis_tvalid && en),
        .v       (p),
        .in_tag  (tag_in),
        .out_vld (lg_vld),
        .lg      (lg),
        .out_tag (lg_tag)
    );

    // Scaling combinational terms.
    always_comb
    begin
        kmul = (tag_t_reg[1].layer == LAYER_STRAT) ? K_STRAT : K_TROPO;
        m3   = 49'(prod2_reg >>> 6);
        lnp3 = lnprod2_reg >>> 30;
        d3   = 38'(C485_Q30) - 38'(lnp3);

        // Floor division by 15625 with one correction step; the magnitude
        // stays below 2^45, so the reciprocal estimate is short by at most one.
        q0_6      = 35'(qprod5_reg >> 46);
        r6        = a5_reg - 48'(48'(q0_6) * 48'd15625);
        q6_next   = q0_6;
        rnz6_next = (r6 != '0);
        if (r6 >= 48'd15625)
        begin
            q6_next   = q0_6 + 35'd1;
            rnz6_next = (r6 != 48'd15625);
        end

        // Isothermal altitude: floor division by 20.
        q20     = yprod4_reg[59:32];
        r20     = y4_reg - 28'(q20 * 28'd20);
        iso_alt = (r20 >= 28'd20) ? q20 + 28'd1 : q20;

        tag5_next = tag_t_reg[4];
        if (tag_t_reg[4].layer == LAYER_ISO)
            tag5_next.aux = AUX_W'(iso_alt);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            // log2 of pressure in kPa.
            lgk1_reg     <= $signed({1'b0, lg}) - T_W'(LOG2_1000);
            tag_t_reg[1] <= lg_tag;
            // Exponent and natural log products.
            prod2_reg    <= 55'(lgk1_reg) * 55'(kmul);
            lnprod2_reg  <= 67'(lgk1_reg) * 67'(LN2_Q30);
            tag_t_reg[2] <= tag_t_reg[1];
            // Magnitude for the division by one million; isothermal numerator.
            neg3_reg     <= m3[48];
            a3_reg       <= m3[48] ? 48'(-m3) : 48'(m3);
            x3_reg       <= 60'(d3) * 60'd1273886 + (60'd10 << 30);
            tag_t_reg[3] <= tag_t_reg[2];
            // Reciprocal partial products, high and low halves of the magnitude.
            pph4_reg     <= 57'(a3_reg[47:24]) * 57'(RECIP_15625);
            ppl4_reg     <= 57'(a3_reg[23:0]) * 57'(RECIP_15625);
            a4_reg       <= a3_reg;
            neg4_reg     <= neg3_reg;
            y4_reg       <= 28'(x3_reg >>> 30);
            yprod4_reg   <= 60'(28'(x3_reg >>> 30)) * 60'(RECIP_20);
            tag_t_reg[4] <= tag_t_reg[3];
            // Full reciprocal product.
            qprod5_reg   <= (81'(pph4_reg) << 24) + 81'(ppl4_reg);
            a5_reg       <= a4_reg;
            neg5_reg     <= neg4_reg;
            tag_t_reg[5] <= tag5_next;
            // Corrected quotients.
            q6_reg       <= q6_next;
            rnz6_reg     <= rnz6_next;
            neg6_reg     <= neg5_reg;
            tag_t_reg[6] <= tag_t_reg[5];
            // Signed floor of the exponent.
            t7_reg       <= neg6_reg ? -T_W'(36'(q6_reg) + 36'(rnz6_reg)) : T_W'(q6_reg);
            tag_t_reg[7] <= tag_t_reg[6];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_t <= '0;
        else if (en)
            vld_t <= {vld_t[5:0], lg_vld};
    end

    bafp_exp2 u_exp2 (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .in_vld  (vld_t[6]),
        .t       (t7_reg),
        .in_tag  (tag_t_reg[7]),
        .out_vld (ex_vld),
        .u       (u),
        .out_tag (ex_tag)
    );

    // Troposphere altitude directly; stratosphere numerator and divisor.
    always_comb
    begin
        u1  = (u == '0) ? U_W'(1) : u;
        cm  = 33'(C165_Q30) - 33'(u1);
        tn2 = (57'sd443975 <<< 31) - 57'(57'(u) * 57'd368740) + (57'sd1 <<< 30);
        tag_d_next = ex_tag;
        if (ex_tag.layer == LAYER_TROPO)
            tag_d_next.aux = AUX_W'(tn2 >>> 31);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= 52'(52'(cm) * 52'd949096) + 52'(u1);
            den_reg[0]  <= 33'(u1) << 1;
            quo_reg[0]  <= '0;
            dtag_reg[0] <= tag_d_next;
        end
    end

    // Restoring divider, one quotient bit per stage from the top.
    for (genvar j = 1; j <= NDIV; j++)
    begin : g_div
        localparam int unsigned B = NDIV - j;
        logic [53:0] sh;
        logic        take;
        assign sh   = 54'(den_reg[j-1]) << B;
        assign take = (54'(rem_reg[j-1]) >= sh);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= take ? 52'(54'(rem_reg[j-1]) - sh) : rem_reg[j-1];
                quo_reg[j]  <= quo_reg[j-1] | (take ? (Q_W'(1) << B) : Q_W'(0));
                den_reg[j]  <= den_reg[j-1];
                dtag_reg[j] <= dtag_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_d <= '0;
        else if (en)
            vld_d <= {vld_d[NDIV-1:0], ex_vld};
    end

    // Select the layer result and clip it to range; a zero sample clips to the top.
    always_comb
    begin
        if (dtag_reg[NDIV].layer == LAYER_STRAT)
            alt_sel = $signed(AUX_W'(quo_reg[NDIV]));
        else
            alt_sel = dtag_reg[NDIV].aux;
        sat_next = 1'b0;
        alt_next = ALT_W'(alt_sel);
        if (dtag_reg[NDIV].zero || alt_sel > ALT_MAX)
        begin
            alt_next = ALT_W'(ALT_MAX);
            sat_next = 1'b1;
        end
        else if (alt_sel < ALT_MIN)
        begin
            alt_next = ALT_W'(ALT_MIN);
            sat_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_reg   <= alt_next;
            layer_reg <= dtag_reg[NDIV].layer;
            sat_reg   <= sat_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= vld_d[NDIV];
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {3'b0, alt_reg};
    assign m_axis_tuser  = {sat_reg, layer_reg};

endmodule

// ===== sv/bafp_check.sv =====
module bafp_check (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [2:0]  m_axis_tuser
);

    // A result held off stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result withdrawn while stalled");

    // A result held off keeps its value.
    a_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // A clipped result sits on one of the range limits.
    a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[2] |->
            $signed(m_axis_tdata[20:0]) == 21'sd1000000 ||
            $signed(m_axis_tdata[20:0]) == -21'sd20000)
        else $error("saturated result off the range limits");

    // An unclipped result lies within range.
    a_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |->
            $signed(m_axis_tdata[20:0]) <= 21'sd1000000 &&
            $signed(m_axis_tdata[20:0]) >= -21'sd20000)
        else $error("unsaturated result out of range");

endmodule

bind barometric_altitude_from_pressure bafp_check u_bafp_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
